/* src/pits_pkg.sv */
// Shared types and constants of the per-place timing statistics block.
`default_nettype none

package pits_pkg;

  localparam int unsigned PLACES_DEF = 64;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_FRAME  = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [31:0] hits;
    logic [31:0] last;
    logic [31:0] peak;
    logic [31:0] mean;
  } entry_t;

endpackage

`default_nettype wire

/* src/per_id_timing_statistics.sv */
// Per-place timing statistics monitor with table memory and iterative divider.
//
// Input channel (in_valid/in_ready) takes one transaction per item: mode,
// place_id and elapsed_time. Output channel (out_valid/out_ready) returns one
// transaction per item with the entry of place_id as it stands after the item,
// plus run_active and run_finished. Config channel (cfg_valid/cfg_ready) writes
// frames_to_profile; it is always ready. The user must write it only while idle;
// the block itself does not enforce this. Items are taken one at a time. A
// sample for a place in range during an active run reads the entry, multiplies
// mean by hit count, adds the sample and divides by the new count with a
// restoring divider of 32 steps at one quotient bit per cycle. All other items
// pass only through the memory read and the result register.
// An end-of-frame item that ends the run is followed by a clearing pass over
// the table memory, one entry per cycle, with in_ready low. After reset the
// same clearing pass runs before the first item is taken. The result register
// holds while out_ready is low; the next item is accepted meanwhile and waits
// for the slot only at its own result.
`default_nettype none

module per_id_timing_statistics #(
  parameter int unsigned PLACES = pits_pkg::PLACES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_mode,
  input  wire  [5:0]  in_place_id,
  input  wire  [31:0] in_elapsed_time,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_last_time,
  output logic [31:0] out_max_time,
  output logic [31:0] out_average_time,
  output logic        out_run_active,
  output logic        out_run_finished
);

  localparam int unsigned AW = (PLACES > 1) ? $clog2(PLACES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(PLACES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic                   prof_on_r, prof_on_nxt;
  logic [31:0]            frames_r, frames_nxt;
  logic [31:0]            cfg_frames_r;
  logic [AW-1:0]          clr_idx_r, clr_idx_nxt;
  logic                   clear_after_r, clear_after_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [1:0]             mode_r;
  logic [AW-1:0]          idx_r;
  logic                   in_range_r;
  logic [31:0]            t_r;
  pits_pkg::entry_t       ent_r, ent_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic [32:0]            rem_r, rem_nxt;
  logic [31:0]            quo_r, quo_nxt;
  logic [32:0]            div_r, div_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  pits_pkg::entry_t       res_r, res_nxt;
  logic                   res_fin_r, res_fin_nxt;
  pits_pkg::entry_t       out_ent_r, out_ent_nxt;
  logic                   out_act_r, out_act_nxt;
  logic                   out_fin_r, out_fin_nxt;

  pits_pkg::entry_t       stats_mem [PLACES];
  pits_pkg::entry_t       rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  pits_pkg::entry_t       mem_wdata;

  logic                   in_fire;
  logic                   in_range;
  pits_pkg::entry_t       hold;
  logic [31:0]            frames_inc;
  logic [63:0]            sum;
  logic [33:0]            trial;
  logic                   load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_range  = 32'(in_place_id) < 32'(PLACES);

  assign out_valid        = out_valid_r;
  assign out_hit_count    = out_ent_r.hits;
  assign out_last_time    = out_ent_r.last;
  assign out_max_time     = out_ent_r.peak;
  assign out_average_time = out_ent_r.mean;
  assign out_run_active   = out_act_r;
  assign out_run_finished = out_fin_r;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stats_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_r <= stats_mem[AW'(in_place_id)];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    prof_on_nxt     = prof_on_r;
    frames_nxt      = frames_r;
    clr_idx_nxt     = clr_idx_r;
    clear_after_nxt = clear_after_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    ent_nxt         = ent_r;
    prod_nxt        = prod_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    div_nxt         = div_r;
    cnt_nxt         = cnt_r;
    res_nxt         = res_r;
    res_fin_nxt     = res_fin_r;
    out_ent_nxt     = out_ent_r;
    out_act_nxt     = out_act_r;
    out_fin_nxt     = out_fin_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = ent_r;
    hold            = in_range_r ? rd_data_r : '0;
    frames_inc      = frames_r + 32'd1;
    sum             = prod_r + {32'd0, t_r};
    trial           = {rem_r, quo_r[31]} - {1'b0, div_r};
    load_out        = !out_valid_r || out_ready;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_nxt     = hold;
        res_fin_nxt = 1'b0;
        state_nxt   = S_OUT;
        unique case (mode_r)
          pits_pkg::MODE_SAMPLE: begin
            if (prof_on_r && in_range_r) begin
              ent_nxt.hits = (rd_data_r.hits == '1) ? rd_data_r.hits
                                                    : rd_data_r.hits + 32'd1;
              ent_nxt.last = t_r;
              ent_nxt.peak = (t_r > rd_data_r.peak) ? t_r : rd_data_r.peak;
              ent_nxt.mean = rd_data_r.mean;
              prod_nxt     = 64'(rd_data_r.mean) * 64'(rd_data_r.hits);
              div_nxt      = {1'b0, rd_data_r.hits} + 33'd1;
              state_nxt    = S_ADD;
            end
          end
          pits_pkg::MODE_FRAME: begin
            if (prof_on_r) begin
              if (frames_inc >= cfg_frames_r) begin
                prof_on_nxt     = 1'b0;
                frames_nxt      = '0;
                res_nxt         = '0;
                res_fin_nxt     = 1'b1;
                clear_after_nxt = 1'b1;
              end else begin
                frames_nxt = frames_inc;
              end
            end
          end
          pits_pkg::MODE_START: begin
            prof_on_nxt = 1'b1;
          end
          pits_pkg::MODE_READ: begin
            res_nxt = hold;
          end
          default: begin
            res_nxt = hold;
          end
        endcase
      end
      S_ADD: begin
        rem_nxt   = {1'b0, sum[63:32]};
        quo_nxt   = sum[31:0];
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!trial[33]) begin
          rem_nxt = trial[32:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_we         = 1'b1;
        mem_wdata      = ent_r;
        mem_wdata.mean = quo_r;
        res_nxt        = mem_wdata;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = res_r;
          out_act_nxt   = prof_on_r;
          out_fin_nxt   = res_fin_r;
          if (clear_after_r) begin
            clear_after_nxt = 1'b0;
            clr_idx_nxt     = '0;
            state_nxt       = S_CLEAR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      prof_on_r     <= 1'b0;
      frames_r      <= '0;
      cfg_frames_r  <= '0;
      clr_idx_r     <= '0;
      clear_after_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prof_on_r     <= prof_on_nxt;
      frames_r      <= frames_nxt;
      clr_idx_r     <= clr_idx_nxt;
      clear_after_r <= clear_after_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_frames_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r     <= in_mode;
      idx_r      <= AW'(in_place_id);
      in_range_r <= in_range;
      t_r        <= in_elapsed_time;
    end
    ent_r     <= ent_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_r     <= div_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    res_fin_r <= res_fin_nxt;
    out_ent_r <= out_ent_nxt;
    out_act_r <= out_act_nxt;
    out_fin_r <= out_fin_nxt;
  end

endmodule

`default_nettype wire

/* src/pits_checker.sv */
// Port-level checker for the per-place timing statistics block, with its bind.
`default_nettype none

module pits_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_hit_count,
  input wire [31:0] out_last_time,
  input wire [31:0] out_max_time,
  input wire [31:0] out_average_time,
  input wire        out_run_active,
  input wire        out_run_finished
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_count)
      && $stable(out_average_time) && $stable(out_run_finished))
    else $error("stalled result changed");

  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_finished |-> !out_run_active && out_hit_count == 32'd0)
    else $error("finished run still active or entry not cleared");

  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_count == 32'd0 |->
      out_last_time == 32'd0 && out_max_time == 32'd0 && out_average_time == 32'd0)
    else $error("entry without hits carries data");

  a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_average_time <= out_max_time)
    else $error("average above maximum");

endmodule

bind per_id_timing_statistics pits_checker u_pits_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit_count    (out_hit_count),
  .out_last_time    (out_last_time),
  .out_max_time     (out_max_time),
  .out_average_time (out_average_time),
  .out_run_active   (out_run_active),
  .out_run_finished (out_run_finished)
);

`default_nettype wire
